// ----- rtl/trilin_pkg.sv -----
// ----------------------------------------------------------------------------
// trilin_pkg
// Shared widths, register indexes and controller/datapath command types for
// the trilinear volume resampler.
// ----------------------------------------------------------------------------
package trilin_pkg;

  localparam int VAL_W    = 16;
  localparam int COORD_W  = 10;
  localparam int ADDR_W   = 15;
  localparam int SHIFT_W  = 20;
  localparam int ISCALE_W = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W    = 8;
  localparam int STEP_W   = 4;
  localparam int STORE_DEPTH = 32768;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_Z = 3'd5;

  localparam logic [ISCALE_W-1:0] INV_SCALE_ONE = 24'd65536;

  // Blend schedule: corner reads on steps 0..7, result written on the last step.
  localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

  typedef struct packed {
    logic              load;
    logic              map;
    logic              check;
    logic              addr1;
    logic              addr2;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              emit_zero;
    logic              emit_val;
  } cmd_t;

  typedef struct packed {
    logic in_range;
  } status_t;

endpackage

// ----- rtl/trilinear_volume_resampler.sv -----
// Compute request: strobe after the blend when inside, after the range test
// when outside; the next request is taken in the cycle the strobe rises.
// Write request: one per cycle while idle. Rate is set by eight corner reads
// from the single-port volume store plus the serial blend chain.
// Reset clears control and configuration; the store holds no reset value.
// ----------------------------------------------------------------------------
// trilinear_volume_resampler
// Trilinear resampling of a source volume held in an on-chip store.
// ----------------------------------------------------------------------------
module trilinear_volume_resampler #(
  parameter int SRC_COLS  = 32,
  parameter int SRC_ROWS  = 32,
  parameter int SRC_BANDS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 action,
  input  logic [trilin_pkg::ADDR_W-1:0]        voxel_address,
  input  logic signed [trilin_pkg::VAL_W-1:0]  voxel_value,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_band,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_row,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_column,
  input  logic                                 cfg_we,
  input  logic [trilin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trilin_pkg::CFG_W-1:0]         cfg_data,
  output logic                                 done,
  output logic signed [trilin_pkg::VAL_W-1:0]  result_value,
  output logic                                 inside_res
);

  trilin_pkg::cmd_t    cmd;
  trilin_pkg::status_t status;

  logic [trilin_pkg::ADDR_W-1:0] rd_addr, ram_addr;
  logic [trilin_pkg::VAL_W-1:0]  rdata;
  logic                          ram_we;

  // writes go straight to the store when the block is idle
  assign ram_we   = start && !busy && !action;
  assign ram_addr = busy ? rd_addr : voxel_address;

  trilin_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  trilin_dp #(
    .SRC_COLS  (SRC_COLS),
    .SRC_ROWS  (SRC_ROWS),
    .SRC_BANDS (SRC_BANDS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .dest_band    (dest_band),
    .dest_row     (dest_row),
    .dest_column  (dest_column),
    .rd_addr      (rd_addr),
    .rdata        (rdata),
    .done         (done),
    .result_value (result_value),
    .inside_res   (inside_res)
  );

  trilin_ram #(
    .WIDTH (trilin_pkg::VAL_W),
    .DEPTH (trilin_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (voxel_value),
    .rdata (rdata)
  );

endmodule

// ----- rtl/trilin_ram.sv -----
// ----------------------------------------------------------------------------
// trilin_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module trilin_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/trilin_ctrl.sv -----
// ----------------------------------------------------------------------------
// trilin_ctrl
// Sequencer: map, range check, address setup and the sixteen-step blend.
// ----------------------------------------------------------------------------
module trilin_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                action,
  input  trilin_pkg::status_t status,
  output trilin_pkg::cmd_t    cmd,
  output logic                busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_ADDR1 = 3'd3;
  localparam logic [2:0] S_ADDR2 = 3'd4;
  localparam logic [2:0] S_RUN   = 3'd5;

  logic [2:0]                    state, state_next;
  logic [trilin_pkg::STEP_W-1:0] step, step_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    step_next     = step;
    cmd           = '0;
    cmd.step      = step;
    case (state)
      S_IDLE: begin
        if (start && action) begin
          cmd.load   = 1'b1;
          state_next = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_ADDR1;
      end
      S_ADDR1: begin
        if (!status.in_range) begin
          cmd.emit_zero = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.addr1  = 1'b1;
          state_next = S_ADDR2;
        end
      end
      S_ADDR2: begin
        cmd.addr2  = 1'b1;
        step_next  = '0;
        state_next = S_RUN;
      end
      S_RUN: begin
        cmd.run   = 1'b1;
        step_next = step + 1'b1;
        if (step == trilin_pkg::STEP_LAST) begin
          cmd.emit_val = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- rtl/trilin_dp.sv -----
// ----------------------------------------------------------------------------
// trilin_dp
// Datapath: configuration registers, axis mapping, corner addressing and the
// three-level blend with truncation and saturation.
// ----------------------------------------------------------------------------
module trilin_dp #(
  parameter int SRC_COLS  = 32,
  parameter int SRC_ROWS  = 32,
  parameter int SRC_BANDS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  trilin_pkg::cmd_t                     cmd,
  output trilin_pkg::status_t                  status,
  input  logic                                 cfg_we,
  input  logic [trilin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trilin_pkg::CFG_W-1:0]         cfg_data,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_band,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_row,
  input  logic [trilin_pkg::COORD_W-1:0]       dest_column,
  output logic [trilin_pkg::ADDR_W-1:0]        rd_addr,
  input  logic [trilin_pkg::VAL_W-1:0]         rdata,
  output logic                                 done,
  output logic signed [trilin_pkg::VAL_W-1:0]  result_value,
  output logic                                 inside_res
);

  localparam logic [trilin_pkg::ADDR_W-1:0] OFF_ROW  =
    trilin_pkg::ADDR_W'(SRC_COLS);
  localparam logic [trilin_pkg::ADDR_W-1:0] OFF_BAND =
    trilin_pkg::ADDR_W'(SRC_ROWS * SRC_COLS);

  logic signed [trilin_pkg::SHIFT_W-1:0] shift_x, shift_y, shift_z;
  logic [trilin_pkg::ISCALE_W-1:0]       inv_scale_x, inv_scale_y, inv_scale_z;

  logic signed [20:0] diff_x, diff_y, diff_z;
  logic signed [45:0] s_x, s_y, s_z;
  logic [trilin_pkg::IDX_W-1:0] idx_b, idx_r, idx_c;
  logic [15:0] wx, wy, wz;
  logic [trilin_pkg::ADDR_W-1:0] row_lin, base;

  logic signed [15:0] x0;
  logic signed [33:0] prod1, c_a, c_b;
  logic signed [51:0] prod2, c0, c1;
  logic signed [52:0] dd;
  logic [41:0]        p3lo;
  logic signed [43:0] p3hi;
  logic signed [69:0] acc;

  logic signed [16:0] d1;
  logic signed [34:0] d2;
  logic signed [33:0] lev1;
  logic signed [51:0] lev2;
  logic in_x, in_y, in_z;
  logic signed [21:0] q, q_adj;
  logic signed [15:0] sat;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_x     <= '0;
      shift_y     <= '0;
      shift_z     <= '0;
      inv_scale_x <= trilin_pkg::INV_SCALE_ONE;
      inv_scale_y <= trilin_pkg::INV_SCALE_ONE;
      inv_scale_z <= trilin_pkg::INV_SCALE_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        trilin_pkg::CFG_SHIFT_X:     shift_x     <= cfg_data[trilin_pkg::SHIFT_W-1:0];
        trilin_pkg::CFG_SHIFT_Y:     shift_y     <= cfg_data[trilin_pkg::SHIFT_W-1:0];
        trilin_pkg::CFG_SHIFT_Z:     shift_z     <= cfg_data[trilin_pkg::SHIFT_W-1:0];
        trilin_pkg::CFG_INV_SCALE_X: inv_scale_x <= cfg_data;
        trilin_pkg::CFG_INV_SCALE_Y: inv_scale_y <= cfg_data;
        trilin_pkg::CFG_INV_SCALE_Z: inv_scale_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // range check: s >= 0 and floor index in 1..size-2
  assign in_x = !s_x[45] && (s_x[45:24] >= 22'd1) &&
                (s_x[45:24] <= 22'(SRC_COLS - 2));
  assign in_y = !s_y[45] && (s_y[45:24] >= 22'd1) &&
                (s_y[45:24] <= 22'(SRC_ROWS - 2));
  assign in_z = !s_z[45] && (s_z[45:24] >= 22'd1) &&
                (s_z[45:24] <= 22'(SRC_BANDS - 2));

  // corner k: bit 0 column+1, bit 1 row+1, bit 2 band+1
  always_comb begin
    rd_addr = base;
    if (cmd.step[0]) rd_addr = rd_addr + 15'd1;
    if (cmd.step[1]) rd_addr = rd_addr + OFF_ROW;
    if (cmd.step[2]) rd_addr = rd_addr + OFF_BAND;
  end

  assign d1   = {rdata[15], rdata} - {x0[15], x0};
  assign lev1 = {{2{x0[15]}}, x0, 16'b0} + prod1;
  assign d2   = {c_b[33], c_b} - {c_a[33], c_a};
  assign lev2 = {{2{c_a[33]}}, c_a, 16'b0} + prod2;

  // truncate toward zero, then clamp
  always_comb begin
    q     = acc[69:48];
    q_adj = q + {21'b0, (acc[69] && (acc[47:0] != 48'b0))};
    if (q_adj > 22'sd32767) begin
      sat = 16'sh7fff;
    end else if (q_adj < -22'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = q_adj[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_x <= $signed({3'b0, dest_column, 8'b0}) - {shift_x[19], shift_x};
      diff_y <= $signed({3'b0, dest_row, 8'b0})    - {shift_y[19], shift_y};
      diff_z <= $signed({3'b0, dest_band, 8'b0})   - {shift_z[19], shift_z};
    end
    if (cmd.map) begin
      s_x <= diff_x * $signed({1'b0, inv_scale_x});
      s_y <= diff_y * $signed({1'b0, inv_scale_y});
      s_z <= diff_z * $signed({1'b0, inv_scale_z});
    end
    if (cmd.check) begin
      status.in_range <= in_x && in_y && in_z;
      idx_c <= s_x[24 +: trilin_pkg::IDX_W];
      idx_r <= s_y[24 +: trilin_pkg::IDX_W];
      idx_b <= s_z[24 +: trilin_pkg::IDX_W];
      wx    <= s_x[23:8];
      wy    <= s_y[23:8];
      wz    <= s_z[23:8];
    end
    if (cmd.addr1) begin
      row_lin <= trilin_pkg::ADDR_W'(32'(idx_b) * SRC_ROWS + 32'(idx_r));
    end
    if (cmd.addr2) begin
      base <= trilin_pkg::ADDR_W'(32'(row_lin) * SRC_COLS + 32'(idx_c));
    end
    if (cmd.run) begin
      case (cmd.step)
        4'd1: x0 <= rdata;
        4'd2: prod1 <= d1 * $signed({1'b0, wx});
        4'd3: begin
          c_a <= lev1;
          x0  <= rdata;
        end
        4'd4: prod1 <= d1 * $signed({1'b0, wx});
        4'd5: begin
          c_b <= lev1;
          x0  <= rdata;
        end
        4'd6: begin
          prod1 <= d1 * $signed({1'b0, wx});
          prod2 <= d2 * $signed({1'b0, wy});
        end
        4'd7: begin
          c0  <= lev2;
          c_a <= lev1;
          x0  <= rdata;
        end
        4'd8: prod1 <= d1 * $signed({1'b0, wx});
        4'd9: c_b <= lev1;
        4'd10: prod2 <= d2 * $signed({1'b0, wy});
        4'd11: c1 <= lev2;
        4'd12: dd <= {c1[51], c1} - {c0[51], c0};
        4'd13: begin
          // split the wide band-axis product into two halves
          p3lo <= dd[25:0] * wz;
          p3hi <= $signed(dd[52:26]) * $signed({1'b0, wz});
        end
        4'd14: acc <= {{2{c0[51]}}, c0, 16'b0} + {p3hi, 26'b0} + {28'b0, p3lo};
        default: begin
        end
      endcase
    end
    if (cmd.emit_zero) begin
      result_value <= '0;
      inside_res   <= 1'b0;
    end else if (cmd.emit_val) begin
      result_value <= sat;
      inside_res   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_zero || cmd.emit_val;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for trilinear_volume_resampler: voxel writes and compute
// requests with random gaps, a built-in trilinear predictor, and a strobe
// checker that compares every result with the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLS = 32;
  localparam int ROWS = 32;
  localparam int BANDS = 32;
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;
  localparam int SETTLE_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [trilin_pkg::VAL_W-1:0] value;
    logic                                in_range;
  } voxel_result_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic action;
  logic [trilin_pkg::ADDR_W-1:0] voxel_address;
  logic signed [trilin_pkg::VAL_W-1:0] voxel_value;
  logic [trilin_pkg::COORD_W-1:0] dest_band, dest_row, dest_column;
  logic cfg_we;
  logic [trilin_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [trilin_pkg::CFG_W-1:0] cfg_data;
  logic done;
  logic signed [trilin_pkg::VAL_W-1:0] result_value;
  logic inside_res;

  // predictor state; axis 0 = column, 1 = row, 2 = band
  logic signed [trilin_pkg::VAL_W-1:0] vol_copy [trilin_pkg::STORE_DEPTH];
  bit written [trilin_pkg::STORE_DEPTH];
  longint axis_shift [3];
  longint axis_iscale [3];
  voxel_result_t pending_q [$];
  int errors = 0;
  longint cycles = 0;
  bit no_gaps = 0;

  trilinear_volume_resampler #(
    .SRC_COLS(COLS), .SRC_ROWS(ROWS), .SRC_BANDS(BANDS)
  ) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .voxel_address(voxel_address), .voxel_value(voxel_value),
    .dest_band(dest_band), .dest_row(dest_row), .dest_column(dest_column),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .result_value(result_value), .inside_res(inside_res)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Map one destination coordinate to a source index and Q0.16 weight.
  function automatic bit map_coord(input logic [trilin_pkg::COORD_W-1:0] d,
                                   input int ax, input int size, output int idx,
                                   output longint w);
    longint diff, s;
    diff = longint'(d) * 256 - axis_shift[ax];
    s = diff * axis_iscale[ax];
    idx = 0;
    w = 0;
    if (s < 0) return 0;
    idx = int'(s >>> 24);
    if (idx < 1 || idx > size - 2) return 0;
    w = (s >>> 8) & 64'hFFFF;
    return 1;
  endfunction

  function automatic int corner_addr(input int b, input int r, input int c);
    return ((b * ROWS + r) * COLS + c) & (trilin_pkg::STORE_DEPTH - 1);
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint w);
    return a * (65536 - w) + b * w;
  endfunction

  function automatic voxel_result_t resample(input logic [trilin_pkg::COORD_W-1:0] b,
                                             input logic [trilin_pkg::COORD_W-1:0] r,
                                             input logic [trilin_pkg::COORD_W-1:0] c);
    voxel_result_t res;
    int bi, ri, ci;
    longint wz, wy, wx, e [2][2], p0, p1, acc, v;
    res.value = '0;
    res.in_range = 1'b0;
    if (!map_coord(b, 2, BANDS, bi, wz) || !map_coord(r, 1, ROWS, ri, wy) ||
        !map_coord(c, 0, COLS, ci, wx))
      return res;
    for (int db = 0; db < 2; db++)
      for (int dr = 0; dr < 2; dr++)
        e[db][dr] = blend(vol_copy[corner_addr(bi + db, ri + dr, ci)],
                          vol_copy[corner_addr(bi + db, ri + dr, ci + 1)], wx);
    p0 = blend(e[0][0], e[0][1], wy);
    p1 = blend(e[1][0], e[1][1], wy);
    acc = blend(p0, p1, wz);
    v = acc / (64'sd1 <<< 48);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    res.value = v[trilin_pkg::VAL_W-1:0];
    res.in_range = 1'b1;
    return res;
  endfunction

  always @(posedge clk) begin
    voxel_result_t exp_r;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: result_value=%0d inside_res=%0b",
               result_value, inside_res);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (result_value !== exp_r.value) begin
          $error("result_value expected %0d actual %0d", exp_r.value, result_value);
          errors++;
        end
        if (inside_res !== exp_r.in_range) begin
          $error("inside_res expected %0b actual %0b", exp_r.in_range, inside_res);
          errors++;
        end
      end
    end
  end

  // Send one request; returns in the step it was accepted, start still high.
  task automatic send_request(input logic act,
                              input logic [trilin_pkg::ADDR_W-1:0] addr,
                              input logic signed [trilin_pkg::VAL_W-1:0] val,
                              input logic [trilin_pkg::COORD_W-1:0] b,
                              input logic [trilin_pkg::COORD_W-1:0] r,
                              input logic [trilin_pkg::COORD_W-1:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    voxel_address <= addr;
    voxel_value <= val;
    dest_band <= b;
    dest_row <= r;
    dest_column <= c;
    do @(posedge clk); while (busy);
    if (act == ACT_WRITE) begin
      vol_copy[addr] = val;
      written[addr] = 1'b1;
    end else begin
      pending_q.push_back(resample(b, r, c));
    end
  endtask

  task automatic write_voxel(input int addr,
                             input logic signed [trilin_pkg::VAL_W-1:0] val);
    send_request(ACT_WRITE, addr[trilin_pkg::ADDR_W-1:0], val,
                 trilin_pkg::COORD_W'($urandom), trilin_pkg::COORD_W'($urandom),
                 trilin_pkg::COORD_W'($urandom));
  endtask

  // Fill any unwritten corner first, so no read ever hits an empty entry.
  task automatic compute_voxel(input logic [trilin_pkg::COORD_W-1:0] b,
                               input logic [trilin_pkg::COORD_W-1:0] r,
                               input logic [trilin_pkg::COORD_W-1:0] c);
    int bi, ri, ci, a;
    longint w;
    if (map_coord(b, 2, BANDS, bi, w) && map_coord(r, 1, ROWS, ri, w) &&
        map_coord(c, 0, COLS, ci, w))
      for (int k = 0; k < 8; k++) begin
        a = corner_addr(bi + k[2], ri + k[1], ci + k[0]);
        if (!written[a]) write_voxel(a, trilin_pkg::VAL_W'($urandom));
      end
    send_request(ACT_COMPUTE, trilin_pkg::ADDR_W'($urandom),
                 trilin_pkg::VAL_W'($urandom), b, r, c);
  endtask

  // Drop start, drain all results, then give the block time to go idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [trilin_pkg::CFG_IDX_W-1:0] idx,
                           input longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[trilin_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= trilin_pkg::CFG_SHIFT_Z)
      axis_shift[idx] = longint'(signed'(val[trilin_pkg::SHIFT_W-1:0]));
    else axis_iscale[idx - trilin_pkg::CFG_INV_SCALE_X] = val & 64'hFFFFFF;
    @(posedge clk);
  endtask

  task automatic set_axes(input longint sx, input longint sy, input longint sz,
                          input longint ix, input longint iy, input longint iz);
    write_reg(trilin_pkg::CFG_SHIFT_X, sx);
    write_reg(trilin_pkg::CFG_SHIFT_Y, sy);
    write_reg(trilin_pkg::CFG_SHIFT_Z, sz);
    write_reg(trilin_pkg::CFG_INV_SCALE_X, ix);
    write_reg(trilin_pkg::CFG_INV_SCALE_Y, iy);
    write_reg(trilin_pkg::CFG_INV_SCALE_Z, iz);
  endtask

  // Pick a coordinate that mostly lands in the valid source range.
  function automatic logic [trilin_pkg::COORD_W-1:0] aim_coord(input int ax);
    longint span, d;
    if ($urandom_range(0, 4) == 0) return trilin_pkg::COORD_W'($urandom);
    span = (axis_iscale[ax] == 0) ? 1023 : (longint'(31) << 16) / axis_iscale[ax] + 2;
    if (span > 1023) span = 1023;
    d = (axis_shift[ax] >>> 8) + $urandom_range(0, int'(span));
    if (d < 0) d = 0;
    if (d > 1023) d = 1023;
    return d[trilin_pkg::COORD_W-1:0];
  endfunction

  task automatic test_identity_mapping();
    compute_voxel(1, 1, 1);
    compute_voxel(30, 30, 30);
    compute_voxel(15, 7, 22);
    compute_voxel(0, 5, 5);
    compute_voxel(5, 31, 5);
    compute_voxel(5, 5, 1023);
    compute_voxel(1023, 1023, 1023);
    compute_voxel(0, 0, 0);
    write_voxel(0, 16'sh7FFF);
    write_voxel(trilin_pkg::STORE_DEPTH - 1, -16'sh8000);
    settle();
  endtask

  task automatic test_value_extremes();
    // all-max and all-min neighborhoods at fractional positions
    set_axes(128, 64, 192, 65536, 65536, 65536);
    for (int k = 0; k < 8; k++) write_voxel(corner_addr(3 + k[2], 3 + k[1], 3 + k[0]),
                                            16'sh7FFF);
    for (int k = 0; k < 8; k++) write_voxel(corner_addr(9 + k[2], 9 + k[1], 9 + k[0]),
                                            -16'sh8000);
    compute_voxel(4, 4, 4);
    compute_voxel(10, 10, 10);
    compute_voxel(3, 3, 3);
    settle();
  endtask

  task automatic test_register_extremes();
    set_axes(524287, -524288, 0, 0, 16777215, 65536);
    compute_voxel(3, 3, 3);
    compute_voxel(1023, 1023, 1023);
    settle();
    set_axes(-524288, 524287, -524288, 16777215, 0, 1);
    compute_voxel(0, 1023, 0);
    compute_voxel(512, 512, 512);
    settle();
    // shift below zero with tiny scale still lands inside
    set_axes(-256, -512, -768, 1024, 2048, 4096);
    compute_voxel(700, 300, 100);
    compute_voxel(1023, 1023, 1023);
    settle();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      no_gaps = (ph == 2);
      set_axes($signed($urandom_range(0, 4096)) - 2048,
               $signed($urandom_range(0, 4096)) - 2048,
               $signed($urandom_range(0, 4096)) - 2048,
               $urandom_range(16384, 131072), $urandom_range(16384, 131072),
               (ph == 5) ? 65536 : $urandom_range(16384, 131072));
      for (int n = 0; n < 325; n++) begin
        if ($urandom_range(0, 4) == 0)
          write_voxel(int'($urandom), trilin_pkg::VAL_W'($urandom));
        else compute_voxel(aim_coord(2), aim_coord(1), aim_coord(0));
      end
      settle();
    end
    no_gaps = 0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    action <= ACT_WRITE;
    voxel_address <= '0;
    voxel_value <= '0;
    dest_band <= '0;
    dest_row <= '0;
    dest_column <= '0;
    cfg_we <= 1'b0;
    cfg_index <= trilin_pkg::CFG_SHIFT_X;
    cfg_data <= '0;
    for (int i = 0; i < trilin_pkg::STORE_DEPTH; i++) begin
      vol_copy[i] = '0;
      written[i] = 1'b0;
    end
    for (int a = 0; a < 3; a++) begin
      axis_shift[a] = 0;
      axis_iscale[a] = trilin_pkg::INV_SCALE_ONE;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_mapping();
    test_value_extremes();
    test_register_extremes();
    test_random_traffic();

    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/trilin_pkg.sv
rtl/trilin_ram.sv
rtl/trilin_ctrl.sv
rtl/trilin_dp.sv
rtl/trilinear_volume_resampler.sv
tb/testbench.sv
